/* rtl/olt_pkg.sv */
package olt_pkg;

  // Table geometry
  localparam int ORDER_SLOTS = 1024;
  localparam int IDX_W       = $clog2(ORDER_SLOTS);
  localparam int ID_W        = 11;
  localparam int CLIENT_W    = 16;
  localparam int QTY_W       = 24;
  localparam int STATUS_W    = 3;
  localparam int OUTCOME_W   = 2;
  localparam int MODE_W      = 2;

  // Stream packing
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 2'd0,
    MODE_EXECUTE = 2'd1,
    MODE_CANCEL  = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

  localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW_ACK    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXEC       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CANCEL_ACK = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CANCEL_REJ = 3'd4;

  localparam logic [OUTCOME_W-1:0] OC_DONE      = 2'd0;
  localparam logic [OUTCOME_W-1:0] OC_NOT_FOUND = 2'd1;
  localparam logic [OUTCOME_W-1:0] OC_SHORT     = 2'd2;
  localparam logic [OUTCOME_W-1:0] OC_FULL      = 2'd3;

  typedef struct packed {
    mode_t               mode;
    logic [ID_W-1:0]     order_id;
    logic [CLIENT_W-1:0] client_id;
    logic [QTY_W-1:0]    quantity;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [QTY_W-1:0]    filled;
    logic [QTY_W-1:0]    quantity;
    logic [CLIENT_W-1:0] client;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]      result_id;
    logic [OUTCOME_W-1:0] outcome;
    logic [STATUS_W-1:0]  order_status;
    logic [QTY_W-1:0]     filled_amount;
    logic [CLIENT_W-1:0]  owner_client;
  } result_t;

  typedef struct packed {
    logic   wr_en;
    logic   is_add;
    entry_t entry;
  } upd_t;

endpackage

/* rtl/olt_exec.sv */
module olt_exec (
  input  olt_pkg::req_t                req,
  input  olt_pkg::entry_t              entry,
  input  logic [olt_pkg::ID_W-1:0]     next_id,
  output olt_pkg::result_t             result,
  output olt_pkg::upd_t                upd
);

  logic                      found;
  logic                      full;
  logic [olt_pkg::QTY_W-1:0] left;
  logic                      cancel_ok;

  assign full  = (next_id >= olt_pkg::ID_W'(olt_pkg::ORDER_SLOTS));
  // Ids are handed out in order and never retired, so an id is live when it
  // lies between one and the count handed out.
  assign found = (req.order_id != '0) && (req.order_id <= next_id);
  assign left  = entry.quantity - entry.filled;
  assign cancel_ok = (entry.status == olt_pkg::ST_NEW_ACK) ||
                     ((entry.status == olt_pkg::ST_EXEC) &&
                      (entry.quantity > entry.filled));

  always_comb begin
    upd                  = '0;
    upd.entry            = entry;
    result.result_id     = req.order_id;
    result.outcome       = olt_pkg::OC_DONE;
    result.order_status  = entry.status;
    result.filled_amount = entry.filled;
    result.owner_client  = entry.client;
    if (req.mode == olt_pkg::MODE_ADD) begin
      if (full) begin
        result = '0;
        result.outcome = olt_pkg::OC_FULL;
      end else begin
        upd.wr_en          = 1'b1;
        upd.is_add         = 1'b1;
        upd.entry.status   = olt_pkg::ST_NEW_ACK;
        upd.entry.filled   = '0;
        upd.entry.quantity = req.quantity;
        upd.entry.client   = req.client_id;
        result.result_id     = next_id + olt_pkg::ID_W'(1);
        result.order_status  = olt_pkg::ST_NEW_ACK;
        result.filled_amount = '0;
        result.owner_client  = req.client_id;
      end
    end else if (!found) begin
      result.outcome       = olt_pkg::OC_NOT_FOUND;
      result.order_status  = olt_pkg::ST_UNKNOWN;
      result.filled_amount = '0;
      result.owner_client  = '0;
    end else begin
      case (req.mode)
        olt_pkg::MODE_EXECUTE: begin
          if (left < req.quantity) begin
            result.outcome = olt_pkg::OC_SHORT;
          end else begin
            upd.wr_en            = 1'b1;
            upd.entry.filled     = entry.filled + req.quantity;
            upd.entry.status     = olt_pkg::ST_EXEC;
            result.order_status  = olt_pkg::ST_EXEC;
            result.filled_amount = entry.filled + req.quantity;
          end
        end
        olt_pkg::MODE_CANCEL: begin
          upd.wr_en           = 1'b1;
          upd.entry.status    = cancel_ok ? olt_pkg::ST_CANCEL_ACK : olt_pkg::ST_CANCEL_REJ;
          result.order_status = cancel_ok ? olt_pkg::ST_CANCEL_ACK : olt_pkg::ST_CANCEL_REJ;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/order_lifecycle_table_core.sv */
// Channel  Direction  Ports                        Beat contents
// in       slave      in_tvalid/tready/tdata/tuser one request (mode in tuser)
// out      master     out_tvalid/tready/tdata      one result per request
//
// A new request beat can be taken in every cycle while the output is not
// stalled; each result passes through the registered read of the entry
// table, then the result register. Synchronous active-low reset empties the
// table at once by clearing the count of ids handed out; the entry memory
// itself is not cleared, and no request beat is taken while reset is held.
// A stalled output holds the second stage, which in turn holds the input
// side; nothing is lost or replayed.
module order_lifecycle_table_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata, from bit 0 up: order_id[10:0], client_id[26:11],
  // quantity[50:27], zero fill[55:51]
  input  logic [olt_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: mode[1:0]
  input  logic [olt_pkg::MODE_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata, from bit 0 up: result_id[10:0], outcome[12:11],
  // order_status[15:13], filled_amount[39:16], owner_client[55:40]
  output logic [olt_pkg::OUT_DATA_W-1:0]     out_tdata
);

  // Entry memory: one word per order, addressed by order id minus one.
  olt_pkg::entry_t mem [olt_pkg::ORDER_SLOTS];

  olt_pkg::req_t                req_in;
  olt_pkg::req_t                s1_req_r;
  logic                         s1_valid_r;
  logic [olt_pkg::IDX_W-1:0]    s1_idx_r;
  olt_pkg::entry_t              rd_entry_r;
  logic                         fwd_hit_r;
  olt_pkg::entry_t              fwd_entry_r;
  logic [olt_pkg::ID_W-1:0]     next_id_r;
  logic [olt_pkg::ID_W-1:0]     next_id_nxt;
  logic                         out_valid_r;
  olt_pkg::result_t             out_res_r;

  logic                         in_fire;
  logic                         s1_fire;
  logic                         wr_fire;
  logic [olt_pkg::IDX_W-1:0]    rd_idx;
  logic [olt_pkg::IDX_W-1:0]    wr_idx;
  logic [olt_pkg::ID_W-1:0]     id_less_one;
  olt_pkg::entry_t              cur_entry;
  olt_pkg::result_t             res;
  olt_pkg::upd_t                upd;

  // Unpack the request beat.
  assign req_in.mode      = olt_pkg::mode_t'(in_tuser);
  assign req_in.order_id  = in_tdata[10:0];
  assign req_in.client_id = in_tdata[26:11];
  assign req_in.quantity  = in_tdata[50:27];

  // The second stage moves on when the result register is free or being
  // emptied; a request enters whenever the second stage is free or moving,
  // and never while reset is held.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!s1_valid_r || s1_fire);
  assign in_fire   = in_tvalid && in_tready;

  assign id_less_one = req_in.order_id - olt_pkg::ID_W'(1);
  assign rd_idx      = id_less_one[olt_pkg::IDX_W-1:0];

  // The request just read sees the memory before the write made by the
  // request ahead of it at the same edge, so that write is forwarded.
  assign cur_entry = fwd_hit_r ? fwd_entry_r : rd_entry_r;

  olt_exec u_exec (
    .req     (s1_req_r),
    .entry   (cur_entry),
    .next_id (next_id_r),
    .result  (res),
    .upd     (upd)
  );

  // An add writes the slot after the last id handed out.
  assign wr_idx  = upd.is_add ? next_id_r[olt_pkg::IDX_W-1:0] : s1_idx_r;
  assign wr_fire = s1_fire && upd.wr_en;

  assign next_id_nxt = (wr_fire && upd.is_add) ? next_id_r + olt_pkg::ID_W'(1) : next_id_r;

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wr_idx] <= upd.entry;
    end
    if (in_fire) begin
      rd_entry_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      next_id_r <= next_id_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= wr_fire && (wr_idx == rd_idx);
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
        fwd_hit_r  <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r    <= req_in;
      s1_idx_r    <= rd_idx;
      fwd_entry_r <= upd.entry;
    end
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.owner_client, out_res_r.filled_amount,
                       out_res_r.order_status, out_res_r.outcome, out_res_r.result_id};

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r <= olt_pkg::ID_W'(olt_pkg::ORDER_SLOTS))
    else $error("id count beyond table size");

  a_write_on_move : assert property (@(posedge clk) disable iff (!rst_n)
    wr_fire |-> s1_valid_r && (!out_valid_r || out_tready))
    else $error("table written without a request moving on");

  a_fwd_needs_req : assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s1_valid_r)
    else $error("forward flag set with second stage empty");

  a_add_counts : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_req_r.mode == olt_pkg::MODE_ADD &&
     next_id_r < olt_pkg::ID_W'(olt_pkg::ORDER_SLOTS))
    |=> next_id_r == $past(next_id_r) + olt_pkg::ID_W'(1))
    else $error("add did not take a new id");

  a_not_found_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.outcome == olt_pkg::OC_NOT_FOUND)
    |-> (out_res_r.order_status == olt_pkg::ST_UNKNOWN && out_res_r.owner_client == '0))
    else $error("unknown order reported with entry contents");
`endif

endmodule
